// ----- rtl/all_pairs_box_overlap_macros.svh -----
// Assertion macros shared by the box overlap block.
`ifndef ALL_PAIRS_BOX_OVERLAP_MACROS_SVH
`define ALL_PAIRS_BOX_OVERLAP_MACROS_SVH

// Same-cycle implication, checked on i_clk and switched off during reset.
`define APBO_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and switched off during reset.
`define APBO_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/apbo_pkg.sv -----
// Shared types, widths and codes of the box overlap block.
package apbo_pkg;

    localparam int MAX_ENTITIES_DEF = 64;
    localparam int REQ_W            = 2;
    localparam int ID_W             = 32;
    localparam int POS_W            = 16;
    localparam int SIZE_W           = 15;
    localparam int ROW_W            = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SCAN   = 2'd2
    } t_req;

    typedef struct packed {
        logic        [SIZE_W-1:0] h;
        logic        [SIZE_W-1:0] w;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic load_a;
        logic cand_load;
        logic out_load_cand;
        logic out_load_none;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/apbo_if.sv -----
// Request and result channel interfaces of the box overlap block.
interface apbo_req_if;
    import apbo_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [ID_W-1:0]          entity_id;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [SIZE_W-1:0]        size_w;
    logic [SIZE_W-1:0]        size_h;
    logic [ROW_W-1:0]         row;

    modport source (output valid, req_type, entity_id, pos_x, pos_y, pos_z, size_w, size_h,
                    row, input ready);
    modport sink (input valid, req_type, entity_id, pos_x, pos_y, pos_z, size_w, size_h,
                  row, output ready);
endinterface

interface apbo_res_if;
    import apbo_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ID_W-1:0]          id_a;
    logic [ID_W-1:0]          id_b;
    logic signed [POS_W-1:0]  a_x;
    logic signed [POS_W-1:0]  a_y;
    logic [SIZE_W-1:0]        a_w;
    logic [SIZE_W-1:0]        a_h;
    logic signed [POS_W-1:0]  b_x;
    logic signed [POS_W-1:0]  b_y;
    logic [SIZE_W-1:0]        b_w;
    logic [SIZE_W-1:0]        b_h;
    logic                     found;
    logic                     last;

    modport source (output valid, id_a, id_b, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                    found, last, input ready);
    modport sink (input valid, id_a, id_b, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
                  found, last, output ready);
endinterface

// ----- rtl/apbo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module apbo_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/apbo_dp.sv -----
// Datapath: entity tables, overlap test, candidate pair and result register.
module apbo_dp #(
    parameter int MAX_ENTITIES = apbo_pkg::MAX_ENTITIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  apbo_pkg::t_dp_cmd                   i_cmd,
    input  logic [$clog2(MAX_ENTITIES)-1:0]     i_wr_addr,
    input  logic [$clog2(MAX_ENTITIES)-1:0]     i_rd_addr,
    input  logic [apbo_pkg::ID_W-1:0]           i_entity_id,
    input  logic signed [apbo_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [apbo_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [apbo_pkg::POS_W-1:0]   i_pos_z,
    input  logic [apbo_pkg::SIZE_W-1:0]         i_size_w,
    input  logic [apbo_pkg::SIZE_W-1:0]         i_size_h,
    output apbo_pkg::t_dp_sts                   o_sts,
    apbo_res_if.source                          o_res
);
    import apbo_pkg::*;

    localparam int SW = POS_W + 2;

    function automatic logic signed [SW-1:0] sx(logic signed [POS_W-1:0] v);
        return {{(SW-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic signed [SW-1:0] zx(logic [SIZE_W-1:0] s);
        return {{(SW-SIZE_W){1'b0}}, s};
    endfunction

    logic signed [POS_W:0]   w_diff;
    logic signed [POS_W-1:0] w_y;
    t_box                    w_wr_box;
    logic [ID_W-1:0]         w_rd_id;
    logic [BOX_W-1:0]        w_rd_raw;
    t_box                    w_b;
    logic signed [SW-1:0]    w_ax, w_ay, w_axe, w_aye, w_bx, w_by, w_bxe, w_bye;
    logic                    w_hit;

    logic [ID_W-1:0]         r_a_id;
    t_box                    r_a_box;
    logic [ID_W-1:0]         r_c_id;
    t_box                    r_c_box;

    logic                    r_o_vld;
    logic [ID_W-1:0]         r_o_id_a;
    logic [ID_W-1:0]         r_o_id_b;
    t_box                    r_o_a;
    t_box                    r_o_b;
    logic                    r_o_found;
    logic                    r_o_last;

    // Projected y = y - z, clamped when the 17-bit difference leaves the 16-bit range.
    assign w_diff = {i_pos_y[POS_W-1], i_pos_y} - {i_pos_z[POS_W-1], i_pos_z};

    always_comb begin
        if (w_diff[POS_W] != w_diff[POS_W-1]) begin
            w_y = w_diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            w_y = w_diff[POS_W-1:0];
        end
    end

    assign w_wr_box = '{h: i_size_h, w: i_size_w, y: w_y, x: i_pos_x};

    apbo_ram #(.W(ID_W), .DEPTH(MAX_ENTITIES)) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_entity_id),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_id)
    );

    apbo_ram #(.W(BOX_W), .DEPTH(MAX_ENTITIES)) u_box_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (w_wr_box),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_b = t_box'(w_rd_raw);

    // Strict overlap at 18 bits, so the far edges cannot wrap.
    assign w_ax  = sx(r_a_box.x);
    assign w_ay  = sx(r_a_box.y);
    assign w_axe = w_ax + zx(r_a_box.w);
    assign w_aye = w_ay + zx(r_a_box.h);
    assign w_bx  = sx(w_b.x);
    assign w_by  = sx(w_b.y);
    assign w_bxe = w_bx + zx(w_b.w);
    assign w_bye = w_by + zx(w_b.h);
    assign w_hit = (w_ax < w_bxe) && (w_bx < w_axe) && (w_ay < w_bye) && (w_by < w_aye);

    assign o_sts.hit      = w_hit;
    assign o_sts.out_free = !r_o_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_a_id  <= w_rd_id;
            r_a_box <= w_b;
        end
        if (i_cmd.cand_load) begin
            r_c_id  <= w_rd_id;
            r_c_box <= w_b;
        end
        if (i_cmd.out_load_cand) begin
            r_o_id_a  <= r_a_id;
            r_o_id_b  <= r_c_id;
            r_o_a     <= r_a_box;
            r_o_b     <= r_c_box;
            r_o_found <= 1'b1;
            r_o_last  <= i_cmd.out_last;
        end else if (i_cmd.out_load_none) begin
            r_o_id_a  <= '0;
            r_o_id_b  <= '0;
            r_o_a     <= '0;
            r_o_b     <= '0;
            r_o_found <= 1'b0;
            r_o_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.out_load_cand || i_cmd.out_load_none) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    assign o_res.valid = r_o_vld;
    assign o_res.id_a  = r_o_id_a;
    assign o_res.id_b  = r_o_id_b;
    assign o_res.a_x   = r_o_a.x;
    assign o_res.a_y   = r_o_a.y;
    assign o_res.a_w   = r_o_a.w;
    assign o_res.a_h   = r_o_a.h;
    assign o_res.b_x   = r_o_b.x;
    assign o_res.b_y   = r_o_b.y;
    assign o_res.b_w   = r_o_b.w;
    assign o_res.b_h   = r_o_b.h;
    assign o_res.found = r_o_found;
    assign o_res.last  = r_o_last;
endmodule

// ----- rtl/apbo_ctrl.sv -----
// Controller: request decode, entity count and the scan sequencer.
module apbo_ctrl #(
    parameter int MAX_ENTITIES = apbo_pkg::MAX_ENTITIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    apbo_req_if.sink                            i_req,
    input  apbo_pkg::t_dp_sts                   i_sts,
    output apbo_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_ENTITIES)-1:0]     o_wr_addr,
    output logic [$clog2(MAX_ENTITIES)-1:0]     o_rd_addr
);
    import apbo_pkg::*;
    `include "all_pairs_box_overlap_macros.svh"

    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam int RW = (ROW_W > CW) ? ROW_W : CW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_j, n_j;
    logic            r_pend, n_pend;
    logic            r_cand_vld, n_cand_vld;
    logic            stall;
    logic            issue;
    logic [RW-1:0]   w_row_ext;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_row_ext   = RW'(i_req.row);

    // A hit that finds the candidate slot taken must wait for the result register.
    assign stall = (r_state == ST_SCAN) && r_pend && i_sts.hit && r_cand_vld
                   && !i_sts.out_free;
    assign issue = !stall && (r_j < r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_j        = r_j;
        n_pend     = r_pend;
        n_cand_vld = r_cand_vld;
        o_cmd      = '0;
        o_wr_addr  = r_count[AW-1:0];
        o_rd_addr  = r_j[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                        REQ_APPEND: begin
                            if (r_count < CW'(MAX_ENTITIES)) begin
                                o_cmd.wr_en = 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        REQ_SCAN: begin
                            if (w_row_ext < RW'(r_count)) begin
                                o_cmd.rd_en = 1'b1;
                                o_rd_addr   = i_req.row[AW-1:0];
                                n_j         = CW'(w_row_ext + 1'b1);
                                n_state     = ST_LOAD_A;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD_A: begin
                o_cmd.load_a = 1'b1;
                n_pend       = 1'b0;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                // Each new hit is held back in the candidate register so the final pair can carry last.
                if (r_pend && i_sts.hit && !stall) begin
                    o_cmd.cand_load     = 1'b1;
                    o_cmd.out_load_cand = r_cand_vld;
                    n_cand_vld          = 1'b1;
                end
                if (!stall) begin
                    o_cmd.rd_en = issue;
                    n_pend      = issue;
                    if (issue) begin
                        n_j = r_j + 1'b1;
                    end
                end
                if (!r_pend && !(r_j < r_count)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    if (r_cand_vld) begin
                        o_cmd.out_load_cand = 1'b1;
                        o_cmd.out_last      = 1'b1;
                    end else begin
                        o_cmd.out_load_none = 1'b1;
                    end
                    n_cand_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_j        <= '0;
            r_pend     <= 1'b0;
            r_cand_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_j        <= n_j;
            r_pend     <= n_pend;
            r_cand_vld <= n_cand_vld;
        end
    end

    `APBO_CHECK(a_count_bound, 1'b1, r_count <= CW'(MAX_ENTITIES), "entity count beyond table")
    `APBO_CHECK(a_cand_src, o_cmd.cand_load, r_pend && i_sts.hit, "candidate taken without hit")
    `APBO_CHECK(a_push_cand, o_cmd.out_load_cand, r_cand_vld && i_sts.out_free, "bad pair push")
    `APBO_CHECK_NEXT(a_finish_done, r_state == ST_FINISH && i_sts.out_free, r_state == ST_IDLE, "scan did not end")
    `APBO_CHECK_NEXT(a_stall_hold, stall, r_pend && $stable(r_j), "stalled compare lost its entry")
endmodule

// ----- rtl/all_pairs_box_overlap.sv -----
// Top level of the all-pairs box overlap block: table of boxes with pair scan.
//
//   channel   direction   transaction
//   i_req     in          clear, append or scan request
//   o_res     out         one overlap pair or a no-pair marker, last on the final one
//
// Clear and append are taken while idle and leave the block idle. During a scan of row i
// over n entities the table has one read port and the sequencer, unless stalled,
// reads one later entry per cycle and tests it against entry i.
// Reset empties the table by zeroing the entity count; the stores themselves are not swept.
// A result waits in the output register; while it is held, a further overlap stalls the scan.
module all_pairs_box_overlap #(
    parameter int MAX_ENTITIES = apbo_pkg::MAX_ENTITIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apbo_req_if.sink    i_req,
    apbo_res_if.source  o_res
);
    import apbo_pkg::*;

    t_dp_cmd                        w_cmd;
    t_dp_sts                        w_sts;
    logic [$clog2(MAX_ENTITIES)-1:0] w_wr_addr;
    logic [$clog2(MAX_ENTITIES)-1:0] w_rd_addr;

    apbo_ctrl #(.MAX_ENTITIES(MAX_ENTITIES)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_wr_addr (w_wr_addr),
        .o_rd_addr (w_rd_addr)
    );

    apbo_dp #(.MAX_ENTITIES(MAX_ENTITIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_wr_addr   (w_wr_addr),
        .i_rd_addr   (w_rd_addr),
        .i_entity_id (i_req.entity_id),
        .i_pos_x     (i_req.pos_x),
        .i_pos_y     (i_req.pos_y),
        .i_pos_z     (i_req.pos_z),
        .i_size_w    (i_req.size_w),
        .i_size_h    (i_req.size_h),
        .o_sts       (w_sts),
        .o_res       (o_res)
    );
endmodule

// ----- dv/all_pairs_box_overlap_tb.sv -----
// Self-checking testbench for the all-pairs box overlap block.
module all_pairs_box_overlap_tb;
    import apbo_pkg::*;

    // Request code 3 has no meaning and must leave the block untouched.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int TABLE_DEPTH  = MAX_ENTITIES_DEF;
    localparam int IDLE_PCT     = 16;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [REQ_W-1:0]        kind;
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic [ROW_W-1:0]        row;
    } t_request;

    typedef struct {
        logic [ID_W-1:0]         id_a;
        logic [ID_W-1:0]         id_b;
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic [SIZE_W-1:0]       a_w;
        logic [SIZE_W-1:0]       a_h;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic [SIZE_W-1:0]       b_w;
        logic [SIZE_W-1:0]       b_h;
        logic                    found;
        logic                    last;
    } t_pair;

    logic i_clk;
    logic i_rst_n;

    apbo_req_if req_if();
    apbo_res_if res_if();

    all_pairs_box_overlap i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of the entity table.
    logic [ID_W-1:0]         tbl_id [TABLE_DEPTH];
    logic signed [POS_W-1:0] tbl_x  [TABLE_DEPTH];
    logic signed [POS_W-1:0] tbl_y  [TABLE_DEPTH];
    logic [SIZE_W-1:0]       tbl_w  [TABLE_DEPTH];
    logic [SIZE_W-1:0]       tbl_h  [TABLE_DEPTH];
    int                      ent_count = 0;

    t_request request_queue[$];
    t_pair    expected_pairs[$];
    t_request offered;

    bit steady        = 1'b0;
    int stall_asked   = 0;
    int stall_granted = 0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int queued_real   = 0;
    int accepted      = 0;
    int scans         = 0;
    int dropped       = 0;
    int most_hits     = 0;
    int checked       = 0;
    int pairs_seen    = 0;
    int errors        = 0;

    function automatic logic signed [POS_W-1:0] project_y(logic signed [POS_W-1:0] y,
                                                         logic signed [POS_W-1:0] z);
        int d;
        d = int'(y) - int'(z);
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        return d[POS_W-1:0];
    endfunction

    // Strict overlap at full width, so touching edges do not count.
    function automatic bit boxes_cross(int i, int j);
        int ax, ay, aw, ah, bx, by, bw, bh;
        ax = tbl_x[i];
        ay = tbl_y[i];
        aw = tbl_w[i];
        ah = tbl_h[i];
        bx = tbl_x[j];
        by = tbl_y[j];
        bw = tbl_w[j];
        bh = tbl_h[j];
        return ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah;
    endfunction

    function automatic void apply_request(t_request rq);
        t_pair p;
        int    hits;
        hits = 0;
        case (rq.kind)
            REQ_CLEAR: begin
                ent_count = 0;
            end
            REQ_APPEND: begin
                if (ent_count < TABLE_DEPTH) begin
                    tbl_id[ent_count] = rq.id;
                    tbl_x[ent_count]  = rq.x;
                    tbl_y[ent_count]  = project_y(rq.y, rq.z);
                    tbl_w[ent_count]  = rq.w;
                    tbl_h[ent_count]  = rq.h;
                    ent_count++;
                end else begin
                    dropped++;
                end
            end
            REQ_SCAN: begin
                scans++;
                for (int j = int'(rq.row) + 1; j < ent_count; j++) begin
                    if (boxes_cross(int'(rq.row), j)) begin
                        p.id_a  = tbl_id[rq.row];
                        p.id_b  = tbl_id[j];
                        p.a_x   = tbl_x[rq.row];
                        p.a_y   = tbl_y[rq.row];
                        p.a_w   = tbl_w[rq.row];
                        p.a_h   = tbl_h[rq.row];
                        p.b_x   = tbl_x[j];
                        p.b_y   = tbl_y[j];
                        p.b_w   = tbl_w[j];
                        p.b_h   = tbl_h[j];
                        p.found = 1'b1;
                        p.last  = 1'b0;
                        expected_pairs = {expected_pairs, p};
                        hits++;
                    end
                end
                if (hits == 0) begin
                    p = '{default: '0};
                    p.last = 1'b1;
                end else begin
                    p = expected_pairs.pop_back();
                    p.last = 1'b1;
                end
                expected_pairs = {expected_pairs, p};
                if (hits > most_hits) most_hits = hits;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic string pair_text(t_pair p);
        return $sformatf({"id_a=%h id_b=%h a=(%0d,%0d,%0d,%0d) b=(%0d,%0d,%0d,%0d) ",
                          "found=%b last=%b"},
                         p.id_a, p.id_b, p.a_x, p.a_y, p.a_w, p.a_h,
                         p.b_x, p.b_y, p.b_w, p.b_h, p.found, p.last);
    endfunction

    function automatic bit pair_differs(t_pair e, t_pair g);
        return e.id_a !== g.id_a || e.id_b !== g.id_b ||
               e.a_x !== g.a_x || e.a_y !== g.a_y || e.a_w !== g.a_w || e.a_h !== g.a_h ||
               e.b_x !== g.b_x || e.b_y !== g.b_y || e.b_w !== g.b_w || e.b_h !== g.b_h ||
               e.found !== g.found || e.last !== g.last;
    endfunction

    function automatic void check_result();
        t_pair got;
        t_pair want;
        got.id_a  = res_if.id_a;
        got.id_b  = res_if.id_b;
        got.a_x   = res_if.a_x;
        got.a_y   = res_if.a_y;
        got.a_w   = res_if.a_w;
        got.a_h   = res_if.a_h;
        got.b_x   = res_if.b_x;
        got.b_y   = res_if.b_y;
        got.b_w   = res_if.b_w;
        got.b_h   = res_if.b_h;
        got.found = res_if.found;
        got.last  = res_if.last;
        if (expected_pairs.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("ERROR: result with nothing outstanding: %s", pair_text(got));
            return;
        end
        want = expected_pairs.pop_front();
        checked++;
        if (got.found === 1'b1) pairs_seen++;
        if (pair_differs(want, got)) begin
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("ERROR: result %0d mismatch", checked);
                $display("  expected %s", pair_text(want));
                $display("  actual   %s", pair_text(got));
            end
        end
    endfunction

    // Request fields that the operation does not use are filled at random.
    function automatic t_request filler(logic [REQ_W-1:0] kind);
        t_request r;
        r.kind = kind;
        r.id   = $urandom;
        r.x    = POS_W'($urandom);
        r.y    = POS_W'($urandom);
        r.z    = POS_W'($urandom);
        r.w    = SIZE_W'($urandom);
        r.h    = SIZE_W'($urandom);
        r.row  = ROW_W'($urandom);
        return r;
    endfunction

    task automatic push_req(t_request r);
        request_queue = {request_queue, r};
        if (r.kind != REQ_SPARE) queued_real++;
    endtask

    task automatic queue_append(logic [ID_W-1:0] id, int x, int y, int z, int w, int h);
        t_request r;
        r = filler(REQ_APPEND);
        r.id = id;
        r.x  = x[POS_W-1:0];
        r.y  = y[POS_W-1:0];
        r.z  = z[POS_W-1:0];
        r.w  = w[SIZE_W-1:0];
        r.h  = h[SIZE_W-1:0];
        push_req(r);
    endtask

    task automatic queue_scan(int row);
        t_request r;
        r = filler(REQ_SCAN);
        r.row = row[ROW_W-1:0];
        push_req(r);
    endtask

    // Boxes are mostly packed into a small area so that overlaps are common.
    task automatic queue_random_append(bit wide);
        if (wide)
            push_req(filler(REQ_APPEND));
        else
            queue_append($urandom, $urandom_range(0, 160) - 80, $urandom_range(0, 160) - 80,
                         $urandom_range(0, 32) - 16, $urandom_range(0, 96),
                         $urandom_range(0, 96));
    endtask

    task automatic queue_batch(int n_ent, int n_scan);
        if ($urandom_range(0, 9) != 0) push_req(filler(REQ_CLEAR));
        for (int k = 0; k < n_ent; k++) begin
            queue_random_append($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 11) == 0) push_req(filler(REQ_SPARE));
        end
        for (int k = 0; k < n_scan; k++) begin
            if ($urandom_range(0, 5) == 0)
                queue_scan($urandom_range(0, 63));
            else
                queue_scan($urandom_range(0, n_ent));
            if ($urandom_range(0, 11) == 0) push_req(filler(REQ_SPARE));
        end
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || req_if.valid === 1'b1 ||
               expected_pairs.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: offers queued requests and updates the prediction on each transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_request(offered);
                accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_queue.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    offered = request_queue.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.req_type  <= offered.kind;
                    req_if.entity_id <= offered.id;
                    req_if.pos_x     <= offered.x;
                    req_if.pos_y     <= offered.y;
                    req_if.pos_z     <= offered.z;
                    req_if.size_w    <= offered.w;
                    req_if.size_h    <= offered.h;
                    req_if.row       <= offered.row;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long back-pressure on the result side, counted here.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_granted != stall_asked) begin
            stall_left    <= STALL_CYCLES;
            stall_granted <= stall_granted + 1;
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            res_if.ready <= (stall_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pairs.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int target;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_CLEAR;
        req_if.entity_id = '0;
        req_if.pos_x     = '0;
        req_if.pos_y     = '0;
        req_if.pos_z     = '0;
        req_if.size_w    = '0;
        req_if.size_h    = '0;
        req_if.row       = '0;
        res_if.ready     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, spare code, touching edges, saturation, extremes.
        queue_scan(0);
        push_req(filler(REQ_SPARE));
        queue_append(32'h0000_0000, 0, 0, 0, 16, 16);
        queue_append(32'hFFFF_FFFF, 16, 0, 0, 16, 16);
        queue_append(32'h1234_5678, 8, 8, 0, 16, 16);
        queue_append(32'h8000_0000, -32768, -32768, 32767, 32767, 32767);
        queue_append(32'h7FFF_FFFF, 32767, 32767, -32768, 32767, 32767);
        queue_append(32'h0000_FFFF, 4, 4, 0, 0, 0);
        queue_append(32'hC3C3_C3C3, -16384, -16384, 0, 32767, 32767);
        queue_append(32'h0001_0000, 0, 16, 0, 16, 16);
        for (int r = 0; r <= 8; r++) queue_scan(r);
        queue_scan(63);
        push_req(filler(REQ_CLEAR));
        queue_scan(0);
        queue_append(32'hA5A5_5A5A, -1, -1, 1, 1, 1);
        queue_scan(0);
        wait_idle();
        target = queued_real + 90;

        // Full table with no idling: every box overlaps the others, then appends are dropped.
        steady = 1'b1;
        push_req(filler(REQ_CLEAR));
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            queue_append($urandom, $urandom_range(0, 64), $urandom_range(0, 64),
                         $urandom_range(0, 8), $urandom_range(80, 128),
                         $urandom_range(80, 128));
        queue_scan(0);
        queue_scan(1);
        queue_scan(62);
        queue_scan(63);
        queue_scan($urandom_range(0, 63));
        wait_idle();
        steady = 1'b0;

        // Results are held back for a long stretch while requests keep coming.
        stall_asked++;
        queue_batch(8, 6);
        wait_idle();

        while (queued_real < target) begin
            queue_batch($urandom_range(2, 10), $urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) wait_idle();
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests, %0d scans, %0d dropped appends, %0s %0d.",
                 accepted, scans, dropped, "most pairs in one scan", most_hits);
        $display("Checked %0d results, %0d of them overlapping pairs, %0d errors.",
                 checked, pairs_seen, errors);
        if (errors == 0 && expected_pairs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- all_pairs_box_overlap.f -----
+incdir+rtl
rtl/apbo_pkg.sv
rtl/apbo_if.sv
rtl/apbo_ram.sv
rtl/apbo_dp.sv
rtl/apbo_ctrl.sv
rtl/all_pairs_box_overlap.sv
dv/all_pairs_box_overlap_tb.sv
